FILE: rtl/pf_pkg.sv
// shared constants for the prime factoriser
`timescale 1ns / 1ps
package pf_pkg;
  localparam int unsigned NUM_WIDTH_DEF   = 32;
  localparam int unsigned PRIME_DEPTH_DEF = 8192;
  localparam int unsigned EXP_WIDTH       = 5;
  localparam int unsigned PRIME_WIDTH     = 16;
endpackage

FILE: rtl/prime_factorizer.sv
// top level of the trial-division prime factoriser
`timescale 1ns / 1ps
//  channel | ports                                            | dir
//  input   | in_valid, in_stall, in_value                     | in
//  result  | out_valid, out_stall, out_prime_factor,          | out
//          | out_exponent, out_is_prime, out_empty_res, out_last
//
// one item at a time; in_stall stays high from acceptance until the last beat is loaded
// factor 2 is stripped first, one trailing zero bit at a time
// each odd trial divisor runs a full bit-serial division, after a table read when taken from the table;
// every division that goes through is followed by another with the same divisor; divisors run up to sqrt,
// so a full-width prime takes about 2^(NUM_WIDTH/2-1) divisors
// synchronous active-low reset; table holds 2 and 3 after reset, count 2
// result beats wait in an output register while out_stall is high
// table filling only changes which divisors are tried faster, never the results
module prime_factorizer #(
  parameter int unsigned NUM_WIDTH   = pf_pkg::NUM_WIDTH_DEF,
  parameter int unsigned PRIME_DEPTH = pf_pkg::PRIME_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [NUM_WIDTH-1:0]          in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [NUM_WIDTH-1:0]          out_prime_factor,
  output logic [pf_pkg::EXP_WIDTH-1:0]  out_exponent,
  output logic                          out_is_prime,
  output logic                          out_empty_res,
  output logic                          out_last
);
  import pf_pkg::*;

  localparam int unsigned AW = (PRIME_DEPTH > 2) ? $clog2(PRIME_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PRIME_DEPTH + 1);
  localparam int unsigned DCW = $clog2(NUM_WIDTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TWO, S_RD, S_RDW, S_CHK, S_DIV, S_DIVEND, S_EMIT, S_TAIL, S_OUT
  } state_t;

  // prime table memory
  logic [PRIME_WIDTH-1:0] mem [PRIME_DEPTH];
  logic [PRIME_WIDTH-1:0] rd_data_r;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [PRIME_WIDTH-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  state_t                 state_r;
  logic [NUM_WIDTH-1:0]   rem_r, d_r, q_r, r_r;
  logic [DCW-1:0]         cnt_r;
  logic [EXP_WIDTH-1:0]   e_r;
  logic                   from_tbl_r, first_r;
  logic [CW-1:0]          idx_r, pcount_r;
  logic                   flush_r;   // when set, the emit ends the item; cleared in S_TWO and never set

  // write table: 2 and 3 at the first two addresses after reset
  logic [1:0] init_r;
  assign rd_addr = idx_r[AW-1:0];

  // divider step
  logic [NUM_WIDTH:0]   trial;
  assign trial = {r_r, q_r[NUM_WIDTH-1]} - {1'b0, d_r};

  // d*d > rem test is done as quotient compare: d > rem/d  <=> quo < d
  logic out_free;
  logic out_load;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((state_r == S_OUT) || (state_r == S_TAIL)
                                 || (state_r == S_EMIT && e_r != '0));
  assign in_stall = (state_r != S_IDLE) || (init_r != 2'd2);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (init_r != 2'd2) begin
      wr_en   = 1'b1;
      wr_addr = AW'(init_r);
      wr_data = (init_r == 2'd0) ? PRIME_WIDTH'(2) : PRIME_WIDTH'(3);
    end else if (state_r == S_EMIT && !from_tbl_r && e_r != '0
                 && pcount_r < CW'(PRIME_DEPTH) && d_r < (NUM_WIDTH'(1) << PRIME_WIDTH)
                 && CW'(idx_r) == pcount_r) begin
      wr_en   = 1'b1;
      wr_addr = pcount_r[AW-1:0];
      wr_data = PRIME_WIDTH'(d_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      init_r    <= 2'd0;
      pcount_r  <= CW'(2);
      out_valid <= 1'b0;
      rem_r     <= '0;
    end else begin
      if (init_r != 2'd2) init_r <= init_r + 2'd1;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            rem_r   <= in_value;
            e_r     <= '0;
            first_r <= 1'b1;
            if (in_value < NUM_WIDTH'(2)) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_TWO;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_prime_factor <= '0;
            out_exponent     <= '0;
            out_is_prime     <= 1'b0;
            out_empty_res    <= 1'b1;
            out_last         <= 1'b1;
            rem_r            <= '0;
            state_r          <= S_IDLE;
          end
        end
        S_TWO: begin
          if (!rem_r[0]) begin
            rem_r <= rem_r >> 1;
            e_r   <= e_r + 1'b1;
          end else begin
            d_r        <= NUM_WIDTH'(2);
            from_tbl_r <= 1'b1;
            flush_r    <= 1'b0;
            idx_r      <= '0;
            state_r    <= S_EMIT;
          end
        end
        S_EMIT: begin
          // present a factor if its exponent is non-zero
          if (e_r == '0 || out_free) begin
            if (e_r != '0) begin
              out_prime_factor <= d_r;
              out_exponent     <= e_r;
              out_is_prime     <= first_r && (rem_r == NUM_WIDTH'(1))
                                  && (e_r == EXP_WIDTH'(1));
              out_empty_res    <= 1'b0;
              out_last         <= flush_r || (rem_r == NUM_WIDTH'(1));
              first_r          <= 1'b0;
              if (wr_en) pcount_r <= pcount_r + 1'b1;
            end
            e_r <= '0;
            if (flush_r || rem_r == NUM_WIDTH'(1)) begin
              rem_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              // past the table end the index follows the next free slot, one beyond once a divisor fails
              if (from_tbl_r || idx_r <= pcount_r) idx_r <= idx_r + 1'b1;
              state_r <= from_tbl_r ? S_RD : S_CHK;
              if (!from_tbl_r) d_r <= d_r + NUM_WIDTH'(2);
            end
          end
        end
        S_RD: begin
          // next divisor from the table while it lasts, else odd stepping
          if (idx_r < pcount_r) begin
            state_r <= S_RDW;
          end else begin
            from_tbl_r <= 1'b0;
            d_r        <= d_r + NUM_WIDTH'(2);
            state_r    <= S_CHK;
          end
        end
        S_RDW: begin
          d_r     <= NUM_WIDTH'(rd_data_r);
          state_r <= S_CHK;
        end
        S_CHK: begin
          q_r     <= rem_r;
          r_r     <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!trial[NUM_WIDTH]) begin
            r_r <= trial[NUM_WIDTH-1:0];
            q_r <= {q_r[NUM_WIDTH-2:0], 1'b1};
          end else begin
            r_r <= {r_r[NUM_WIDTH-2:0], q_r[NUM_WIDTH-1]};
            q_r <= {q_r[NUM_WIDTH-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DCW'(NUM_WIDTH - 1)) state_r <= S_DIVEND;
        end
        S_DIVEND: begin
          if (r_r == '0) begin
            // divides: take it out and try again
            rem_r   <= q_r;
            e_r     <= e_r + 1'b1;
            state_r <= S_CHK;
          end else if (e_r != '0) begin
            state_r <= S_EMIT;
          end else if (q_r < d_r) begin
            // d*d > remainder: what is left is prime
            state_r <= S_TAIL;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_TAIL: begin
          if (out_free) begin
            out_prime_factor <= rem_r;
            out_exponent     <= EXP_WIDTH'(1);
            out_is_prime     <= first_r;
            out_empty_res    <= 1'b0;
            out_last         <= 1'b1;
            rem_r            <= '0;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/pf_checker.sv
// port-level checker for the prime factoriser, bound to the top level
`timescale 1ns / 1ps
module pf_assertions #(
  parameter int unsigned NUM_WIDTH = pf_pkg::NUM_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [NUM_WIDTH-1:0]         out_prime_factor,
  input logic [pf_pkg::EXP_WIDTH-1:0] out_exponent,
  input logic                         out_empty_res,
  input logic                         out_last
);
  import pf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prime_factor))
    else $error("stalled result beat changed");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && out_prime_factor == '0 && out_exponent == '0)
    else $error("empty beat malformed");
  a_exp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_res |-> out_exponent != '0)
    else $error("factor with zero exponent");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken mid item");
endmodule

bind prime_factorizer pf_assertions #(.NUM_WIDTH(NUM_WIDTH)) u_pf_assertions (.*);

FILE: test/pf_checker.sv
// result checker for the prime factoriser: predicts factor beats and compares them
`timescale 1ns / 1ps
module pf_checker #(
  parameter int unsigned NUM_WIDTH = pf_pkg::NUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [NUM_WIDTH-1:0]          in_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [NUM_WIDTH-1:0]          out_prime_factor,
  input  logic [pf_pkg::EXP_WIDTH-1:0]  out_exponent,
  input  logic                          out_is_prime,
  input  logic                          out_empty_res,
  input  logic                          out_last,
  output int                            fail_count,
  output int                            factors_pending,
  output int                            beats_seen
);

  localparam int unsigned EW = pf_pkg::EXP_WIDTH;

  typedef struct packed {
    logic [NUM_WIDTH-1:0]         factor;
    logic [pf_pkg::EXP_WIDTH-1:0] expo;
    logic                         prime;
    logic                         empty;
    logic                         last;
  } factor_beat_t;

  factor_beat_t factor_q[$];

  // trial division of one value into expected factor beats
  function automatic void factorise(input logic [NUM_WIDTH-1:0] value);
    factor_beat_t beats[$];
    factor_beat_t b;
    longint unsigned rem;
    longint unsigned d;
    int unsigned e;
    rem = 64'(value);
    if (rem < 2) begin
      b = '{factor: '0, expo: '0, prime: 1'b0, empty: 1'b1, last: 1'b1};
      factor_q.push_back(b);
      return;
    end
    e = 0;
    while (rem[0] == 1'b0) begin
      rem = rem >> 1;
      e++;
    end
    if (e != 0) begin
      b = '{factor: NUM_WIDTH'(2), expo: EW'(e), prime: 1'b0, empty: 1'b0, last: 1'b0};
      beats.push_back(b);
    end
    d = 3;
    while (rem > 1 && d <= rem / d) begin
      if (rem % d == 0) begin
        e = 0;
        while (rem % d == 0) begin
          rem = rem / d;
          e++;
        end
        b = '{factor: NUM_WIDTH'(d), expo: EW'(e), prime: 1'b0, empty: 1'b0, last: 1'b0};
        beats.push_back(b);
      end
      d += 2;
    end
    if (rem > 1) begin
      b = '{factor: NUM_WIDTH'(rem), expo: EW'(1), prime: 1'b0, empty: 1'b0, last: 1'b0};
      beats.push_back(b);
    end
    for (int i = 0; i < beats.size(); i++) begin
      beats[i].prime = (beats.size() == 1 && beats[0].expo == 1);
      beats[i].last  = (i == beats.size() - 1);
      factor_q.push_back(beats[i]);
    end
  endfunction

  always @(posedge clk) begin
    factor_beat_t got;
    factor_beat_t want;
    if (!rst_n) begin
      fail_count = 0;
      beats_seen = 0;
      factor_q.delete();
    end else begin
      if (in_valid && !in_stall)
        factorise(in_value);
      if (out_valid && !out_stall) begin
        got = '{factor: out_prime_factor, expo: out_exponent, prime: out_is_prime,
                empty: out_empty_res, last: out_last};
        beats_seen++;
        if (factor_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected beat: factor %0d exp %0d prime %0b empty %0b last %0b",
                     got.factor, got.expo, got.prime, got.empty, got.last);
        end else begin
          want = factor_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp factor %0d exp %0d prime %0b empty %0b last %0b",
                       want.factor, want.expo, want.prime, want.empty, want.last);
              $display("          got factor %0d exp %0d prime %0b empty %0b last %0b",
                       got.factor, got.expo, got.prime, got.empty, got.last);
            end
          end
        end
      end
    end
    factors_pending = factor_q.size();
  end

endmodule

FILE: test/tb_prime_factorizer.sv
// testbench top for the prime factoriser: stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_prime_factorizer;

  localparam int unsigned NW = pf_pkg::NUM_WIDTH_DEF;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [NW-1:0]                 in_value;
  logic                          out_valid;
  logic                          out_stall;
  logic [NW-1:0]                 out_prime_factor;
  logic [pf_pkg::EXP_WIDTH-1:0]  out_exponent;
  logic                          out_is_prime;
  logic                          out_empty_res;
  logic                          out_last;

  int fail_count;
  int factors_pending;
  int beats_seen;
  int items_sent;
  bit hold_off_req;   // asks the receiver for one long stall stretch
  bit stream_mode;    // sender offers beats back to back

  prime_factorizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_prime_factor(out_prime_factor), .out_exponent(out_exponent),
    .out_is_prime(out_is_prime), .out_empty_res(out_empty_res), .out_last(out_last)
  );

  pf_checker #(.NUM_WIDTH(NW)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_prime_factor(out_prime_factor), .out_exponent(out_exponent),
    .out_is_prime(out_is_prime), .out_empty_res(out_empty_res), .out_last(out_last),
    .fail_count(fail_count), .factors_pending(factors_pending), .beats_seen(beats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop, well above a run of many full-width primes
  initial begin
    #2_000_000_000;
    $display("timeout with %0d beats still expected", factors_pending);
    $display("FAILED: results differ");
    $finish;
  end

  // offer one input beat, hold it until accepted
  task automatic send_value(input logic [NW-1:0] v);
    int gap;
    gap = stream_mode ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // small primes for building smooth numbers
  function automatic logic [NW-1:0] smooth_value();
    int unsigned plist[10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
    longint unsigned acc;
    longint unsigned p;
    int n;
    acc = 1;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      p = plist[$urandom_range(0, 9)];
      // an occasional mid-sized odd factor keeps the tail non-trivial
      if ($urandom_range(0, 7) == 0)
        p = $urandom_range(31, 4000) | 1;
      if (acc * p <= 64'hFFFF_FFFF)
        acc = acc * p;
    end
    return acc[NW-1:0];
  endfunction

  // receiver: random stall before each beat, plus one long hold-off on request
  initial begin
    int wait_cycles;
    bit held;
    held = 1'b0;
    out_stall <= 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_off_req && !held) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        held = 1'b1;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [NW-1:0] directed[$];
    int pick;
    in_valid     = 1'b0;
    in_value     = '0;
    rst_n        = 1'b0;
    items_sent   = 0;
    hold_off_req = 1'b0;
    stream_mode  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty inputs, smallest primes, extremes, deep exponents
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd9, 32'd25,
                 32'd97, 32'd65537, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE,
                 32'd223092870, 32'd3486784401, 32'd4294967291, 32'd1048576,
                 32'd999983, 32'd2147483647};
    foreach (directed[i]) send_value(directed[i]);

    // sender pauses until every expected beat has come back
    in_valid <= 1'b0;
    @(posedge clk);
    while (factors_pending != 0) @(posedge clk);

    // long receiver hold-off while the sender streams smooth values
    hold_off_req = 1'b1;
    stream_mode  = 1'b1;
    for (int i = 0; i < 12; i++) send_value(smooth_value());
    stream_mode = 1'b0;

    // random mix, mostly cheap to factor, a few full-width values
    for (int i = 0; i < 70; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)       send_value(smooth_value());
      else if (pick < 75)  send_value($urandom_range(0, 65535));
      else if (pick < 97)  send_value($urandom() >> $urandom_range(8, 31));
      else                 send_value($urandom());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (factors_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sent %0d values including empty, prime, power-of-two and nine-factor cases",
             items_sent);
    $display("checked %0d factor beats under random and long output stalls", beats_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pf_pkg.sv
rtl/prime_factorizer.sv
rtl/pf_checker.sv
test/pf_checker.sv
test/tb_prime_factorizer.sv
